// ----- hw/rtl/fsp_pkg.sv -----
// Shared types and constants of the FASTA stream parser.
// Used by the front end, the command queue and the back end.
`default_nettype none

package fsp_pkg;

    // Name lengths and store addresses travel at this fixed width (names up to 62 bytes).
    localparam int LEN_W       = 6;
    localparam int SPACE_W     = 12;
    localparam int MAX_RESULTS = 64;

    localparam logic [SPACE_W-1:0] SPACE_SAT     = '1;
    // Run cap when a held CR and one more byte both land in the same transfer.
    localparam logic [LEN_W-1:0]   RUN_CAP_SHORT = LEN_W'(MAX_RESULTS - 3);

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [1:0] KIND_SEQ  = 2'd0;
    localparam logic [1:0] KIND_SEP  = 2'd1;
    localparam logic [1:0] KIND_NAME = 2'd2;
    localparam logic [1:0] KIND_NEND = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Everything one input byte asks the back end to emit, in emission order:
    // separator, name run, first sequence byte, second sequence byte.
    typedef struct packed {
        logic               sep;
        logic               run;
        logic [LEN_W-1:0]   run_len;
        logic               seq0;
        logic [7:0]         byte0;
        logic [SPACE_W-1:0] spaces0;
        logic               seq1;
        logic [7:0]         byte1;
    } cmd_t;

    localparam cmd_t CMD_NONE = '{default: '0};

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fsp_if.sv -----
// Valid/ready channel interfaces of the FASTA stream parser.
// Depends on nothing; widths follow the text and result fields.
`default_nettype none

interface fsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface fsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [11:0] spaces_before;
    logic        run_last;

    modport source (output valid, output kind, output out_byte, output spaces_before,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input out_byte, input spaces_before,
                    input run_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fsp_front.sv -----
// Front end: accepts text bytes, tracks line and record state, writes header
// names to the name store and pushes at most one command per byte. Uses fsp_pkg, fsp_if.
`default_nettype none

module fsp_front #(
    parameter int NAME_MAX = 62
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fsp_in_if.sink             text_in,
    input  wire logic          q_full,
    input  wire logic          run_done,
    output fsp_pkg::cmd_t      push_cmd,
    output logic               push,
    output fsp_pkg::wr_t       store_wr
);

    localparam int LW = $clog2(NAME_MAX + 1);

    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_SEQ   = 5'b00010,
        MODE_HLEAD = 5'b00100,
        MODE_HNAME = 5'b01000,
        MODE_HREST = 5'b10000
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic                           cr_pending_reg, cr_pending_next;
    logic [fsp_pkg::SPACE_W-1:0]    pending_spaces_reg, pending_spaces_next;
    logic                           line_has_text_reg, line_has_text_next;
    logic                           record_has_seq_reg, record_has_seq_next;
    logic [LW-1:0]                  name_length_reg, name_length_next;
    fsp_pkg::cmd_t                  hold_reg, hold_next;
    logic                           run_wait_reg, run_wait_next;

    logic [7:0] c;
    logic       is_lf;
    logic       is_cr;
    logic       cr_step;
    logic       accept;
    logic       take_active;
    logic       apply;
    logic       res_short;

    logic [7:0]                  tk_ch;
    mode_t                       tk_mode;
    logic [fsp_pkg::SPACE_W-1:0] tk_ps;
    logic                        tk_lht;
    logic                        tk_rhs;
    logic [LW-1:0]               tk_nlen;
    fsp_pkg::cmd_t               tk_cmd;
    fsp_pkg::wr_t                tk_wr;
    logic                        seq_now;
    logic                        lht_eff;
    logic [fsp_pkg::SPACE_W-1:0] ps_eff;
    logic [fsp_pkg::LEN_W-1:0]   nlen_wide;
    fsp_pkg::cmd_t               cur_cmd;

    function automatic fsp_pkg::cmd_t merge_cmd(fsp_pkg::cmd_t a, fsp_pkg::cmd_t b);
        fsp_pkg::cmd_t m;
        m         = fsp_pkg::CMD_NONE;
        m.sep     = a.sep | b.sep;
        m.run     = a.run | b.run;
        m.run_len = a.run ? a.run_len : b.run_len;
        m.seq0    = a.seq0 | b.seq0;
        m.byte0   = a.seq0 ? a.byte0 : b.byte0;
        m.spaces0 = a.seq0 ? a.spaces0 : b.spaces0;
        m.seq1    = a.seq0 & b.seq0;
        m.byte1   = b.byte0;
        return m;
    endfunction

    assign c     = text_in.text_byte;
    assign is_lf = (c == fsp_pkg::CH_LF);
    assign is_cr = (c == fsp_pkg::CH_CR);

    // A held CR in front of an ordinary byte is worked off in a step of its own, before that byte is taken.
    assign cr_step = text_in.valid && !run_wait_reg && !q_full
                     && cr_pending_reg && !is_lf && !is_cr;
    assign text_in.ready = !run_wait_reg && !q_full && !(cr_pending_reg && !is_lf && !is_cr);
    assign accept        = text_in.valid && text_in.ready;
    assign take_active   = !is_lf && (!is_cr || cr_pending_reg);
    assign apply         = cr_step || (accept && take_active);
    assign res_short     = cr_step && (c != fsp_pkg::CH_SPACE);

    assign tk_ch     = (cr_pending_reg && !is_lf) ? fsp_pkg::CH_CR : c;
    assign nlen_wide = fsp_pkg::LEN_W'(name_length_reg);

    // One character through the line state machine.
    always_comb
    begin
        tk_mode = mode_reg;
        tk_ps   = pending_spaces_reg;
        tk_lht  = line_has_text_reg;
        tk_rhs  = record_has_seq_reg;
        tk_nlen = name_length_reg;
        tk_cmd  = fsp_pkg::CMD_NONE;
        tk_wr   = '0;
        seq_now = (mode_reg == MODE_SEQ)
                  || (mode_reg == MODE_START && tk_ch != fsp_pkg::CH_GT);
        lht_eff = (mode_reg == MODE_START) ? 1'b0 : line_has_text_reg;
        ps_eff  = (mode_reg == MODE_START) ? '0 : pending_spaces_reg;

        unique case (mode_reg)
            MODE_START:
            begin
                if (tk_ch == fsp_pkg::CH_GT)
                begin
                    tk_cmd.sep = record_has_seq_reg;
                    tk_rhs     = 1'b0;
                    tk_nlen    = '0;
                    tk_mode    = MODE_HLEAD;
                end
                else
                begin
                    tk_mode = MODE_SEQ;
                    tk_lht  = 1'b0;
                    tk_ps   = '0;
                end
            end
            MODE_HLEAD, MODE_HNAME:
            begin
                if (tk_ch == fsp_pkg::CH_SPACE)
                begin
                    if (mode_reg == MODE_HNAME)
                    begin
                        tk_mode = MODE_HREST;
                    end
                end
                else
                begin
                    tk_mode = MODE_HNAME;
                    if (name_length_reg < LW'(NAME_MAX))
                    begin
                        tk_wr.en   = 1'b1;
                        tk_wr.addr = nlen_wide;
                        tk_wr.data = tk_ch;
                        tk_nlen    = LW'(name_length_reg + 1'b1);
                    end
                end
            end
            MODE_SEQ, MODE_HREST:
            begin
            end
            default:
            begin
            end
        endcase

        if (seq_now)
        begin
            if (tk_ch == fsp_pkg::CH_SPACE)
            begin
                // count only interior spaces; leading ones are trimmed
                if (lht_eff && ps_eff != fsp_pkg::SPACE_SAT)
                begin
                    tk_ps = ps_eff + 1'b1;
                end
            end
            else
            begin
                if (!record_has_seq_reg)
                begin
                    tk_cmd.run     = 1'b1;
                    tk_cmd.run_len = (res_short && nlen_wide > fsp_pkg::RUN_CAP_SHORT)
                                     ? fsp_pkg::RUN_CAP_SHORT : nlen_wide;
                    tk_rhs         = 1'b1;
                end
                tk_cmd.seq0    = 1'b1;
                tk_cmd.byte0   = (tk_ch >= fsp_pkg::CH_UPPER_A && tk_ch <= fsp_pkg::CH_UPPER_Z)
                                 ? tk_ch + fsp_pkg::CASE_OFFSET : tk_ch;
                tk_cmd.spaces0 = ps_eff;
                tk_ps          = '0;
                tk_lht         = 1'b1;
            end
        end
    end

    assign cur_cmd  = (accept && take_active) ? tk_cmd : fsp_pkg::CMD_NONE;
    assign push_cmd = merge_cmd(hold_reg, cur_cmd);
    assign push     = accept && (push_cmd.sep || push_cmd.run || push_cmd.seq0);

    always_comb
    begin
        store_wr    = tk_wr;
        store_wr.en = tk_wr.en && apply;
    end

    always_comb
    begin
        mode_next           = mode_reg;
        cr_pending_next     = cr_pending_reg;
        pending_spaces_next = pending_spaces_reg;
        line_has_text_next  = line_has_text_reg;
        record_has_seq_next = record_has_seq_reg;
        name_length_next    = name_length_reg;
        hold_next           = hold_reg;
        run_wait_next       = run_wait_reg;

        if (apply)
        begin
            mode_next           = tk_mode;
            pending_spaces_next = tk_ps;
            line_has_text_next  = tk_lht;
            record_has_seq_next = tk_rhs;
            name_length_next    = tk_nlen;
        end

        if (cr_step)
        begin
            cr_pending_next = 1'b0;
            hold_next       = tk_cmd;
        end

        if (accept)
        begin
            hold_next = fsp_pkg::CMD_NONE;
            if (is_lf)
            begin
                mode_next           = MODE_START;
                cr_pending_next     = 1'b0;
                pending_spaces_next = '0;
                line_has_text_next  = 1'b0;
            end
            else if (is_cr)
            begin
                cr_pending_next = 1'b1;
            end
            // end of file: drop any held CR and start over
            if (text_in.final_byte)
            begin
                mode_next           = MODE_START;
                cr_pending_next     = 1'b0;
                pending_spaces_next = '0;
                line_has_text_next  = 1'b0;
                record_has_seq_next = 1'b0;
                name_length_next    = '0;
            end
        end

        // hold input while the back end still reads the name store
        if (push && push_cmd.run)
        begin
            run_wait_next = 1'b1;
        end
        else if (run_done)
        begin
            run_wait_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_START;
            cr_pending_reg     <= 1'b0;
            pending_spaces_reg <= '0;
            line_has_text_reg  <= 1'b0;
            record_has_seq_reg <= 1'b0;
            name_length_reg    <= '0;
            hold_reg           <= fsp_pkg::CMD_NONE;
            run_wait_reg       <= 1'b0;
        end
        else
        begin
            mode_reg           <= mode_next;
            cr_pending_reg     <= cr_pending_next;
            pending_spaces_reg <= pending_spaces_next;
            line_has_text_reg  <= line_has_text_next;
            record_has_seq_reg <= record_has_seq_next;
            name_length_reg    <= name_length_next;
            hold_reg           <= hold_next;
            run_wait_reg       <= run_wait_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fsp_queue.sv -----
// Short command queue between the front end and the back end.
// Uses fsp_pkg for the command type and depth.
`default_nettype none

module fsp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fsp_pkg::cmd_t  push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output fsp_pkg::cmd_t       head
);

    fsp_pkg::cmd_t                entries_reg [fsp_pkg::Q_DEPTH];
    logic [fsp_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [fsp_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [fsp_pkg::Q_PTR_W:0]    count_reg, count_next;

    assign full  = (count_reg == (fsp_pkg::Q_PTR_W + 1)'(fsp_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fsp_back.sv -----
// Back end: expands queued commands into result transfers, holds the name
// store and reads name runs out of it. Uses fsp_pkg and fsp_if.
`default_nettype none

module fsp_back #(
    parameter int NAME_MAX = 62
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fsp_out_if.source          parsed_out,
    input  wire fsp_pkg::wr_t  store_wr,
    input  wire logic          q_empty,
    input  wire fsp_pkg::cmd_t q_head,
    output logic               pop,
    output logic               run_done
);

    localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_SEP  = 6'b000010,
        PH_NAME = 6'b000100,
        PH_NEND = 6'b001000,
        PH_SEQ0 = 6'b010000,
        PH_SEQ1 = 6'b100000
    } phase_t;

    logic [7:0]                  name_mem [NAME_MAX];
    logic [7:0]                  rdata_reg;

    phase_t                      phase_reg, phase_next;
    fsp_pkg::cmd_t               cmd_reg, cmd_next;
    logic [fsp_pkg::LEN_W-1:0]   idx_reg, idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  kind_reg;
    logic [7:0]                  byte_reg;
    logic [fsp_pkg::SPACE_W-1:0] spaces_reg;
    logic                        last_reg;

    logic                        out_free;
    logic                        emit;
    logic                        load;
    phase_t                      ph_after;
    logic [1:0]                  kind_cur;
    logic [7:0]                  byte_cur;
    logic [fsp_pkg::SPACE_W-1:0] spaces_cur;

    function automatic phase_t pick(logic sep, logic run, logic [fsp_pkg::LEN_W-1:0] len,
                                    logic seq0, logic seq1);
        phase_t p;
        p = PH_IDLE;
        if (sep)
        begin
            p = PH_SEP;
        end
        else if (run)
        begin
            p = (len != '0) ? PH_NAME : PH_NEND;
        end
        else if (seq0)
        begin
            p = PH_SEQ0;
        end
        else if (seq1)
        begin
            p = PH_SEQ1;
        end
        return p;
    endfunction

    assign out_free = !out_valid_reg || parsed_out.ready;
    assign emit     = out_free && (phase_reg != PH_IDLE);

    always_comb
    begin
        unique case (phase_reg)
            PH_SEP:  ph_after = pick(1'b0, cmd_reg.run, cmd_reg.run_len, cmd_reg.seq0,
                                     cmd_reg.seq1);
            PH_NAME: ph_after = (idx_reg == fsp_pkg::LEN_W'(cmd_reg.run_len - 1'b1))
                                ? PH_NEND : PH_NAME;
            PH_NEND: ph_after = pick(1'b0, 1'b0, '0, cmd_reg.seq0, cmd_reg.seq1);
            PH_SEQ0: ph_after = pick(1'b0, 1'b0, '0, 1'b0, cmd_reg.seq1);
            PH_SEQ1: ph_after = PH_IDLE;
            default: ph_after = PH_IDLE;
        endcase
    end

    // Take the next command as soon as the current one hands out its last transfer.
    assign load     = !q_empty && (phase_reg == PH_IDLE || (emit && ph_after == PH_IDLE));
    assign pop      = load;
    assign run_done = emit && (phase_reg == PH_NEND);

    always_comb
    begin
        kind_cur   = fsp_pkg::KIND_SEQ;
        byte_cur   = '0;
        spaces_cur = '0;
        unique case (phase_reg)
            PH_SEP:
            begin
                kind_cur = fsp_pkg::KIND_SEP;
            end
            PH_NAME:
            begin
                kind_cur = fsp_pkg::KIND_NAME;
                byte_cur = rdata_reg;
            end
            PH_NEND:
            begin
                kind_cur = fsp_pkg::KIND_NEND;
            end
            PH_SEQ0:
            begin
                byte_cur   = cmd_reg.byte0;
                spaces_cur = cmd_reg.spaces0;
            end
            PH_SEQ1:
            begin
                byte_cur = cmd_reg.byte1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            phase_next = ph_after;
            if (phase_reg == PH_NAME && ph_after == PH_NAME)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load)
        begin
            phase_next = pick(q_head.sep, q_head.run, q_head.run_len, q_head.seq0, q_head.seq1);
            cmd_next   = q_head;
            idx_next   = '0;
        end
        out_valid_next = emit ? 1'b1 : (parsed_out.ready ? 1'b0 : out_valid_reg);
    end

    // Name store: written by the front end; the read is registered and addressed by the next index.
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            name_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
        end
        rdata_reg <= name_mem[idx_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg   <= kind_cur;
            byte_reg   <= byte_cur;
            spaces_reg <= spaces_cur;
            last_reg   <= (ph_after == PH_IDLE);
        end
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign parsed_out.valid         = out_valid_reg;
    assign parsed_out.kind          = kind_reg;
    assign parsed_out.out_byte      = byte_reg;
    assign parsed_out.spaces_before = spaces_reg;
    assign parsed_out.run_last      = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fasta_stream_parser.sv -----
// FASTA stream parser: top level, joins front end, command queue and back end.
// Uses fsp_pkg, fsp_if, fsp_front, fsp_queue and fsp_back.
//
// text_in takes one byte of FASTA text per transfer, with final_byte on the
// last byte of a file. parsed_out gives the parsed stream: sequence bytes
// (lowercased, with the count of interior spaces before them), record
// separators, name bytes and name ends; run_last marks the last result of
// each input byte. A byte that yields no result yields no transfer.
// A byte's command passes the command queue and the back end's command
// register before its first result is registered at parsed_out; a held CR
// that is worked off first also passes the front end's hold register. The
// back end hands out one result per cycle while parsed_out is ready; text_in
// takes one byte per cycle while each byte gives at most one result and
// parsed_out is ready. An ordinary byte after a held CR waits for the CR;
// a byte opening a record's sequence holds text_in until the name run is out.
// The 4-entry command queue fills when parsed_out stalls, and text_in then
// drops ready. Reset clears all line and record state and the queue; the
// name store holds no reset value and is read only where it was written.
`default_nettype none

module fasta_stream_parser #(
    parameter int NAME_MAX = 62
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsp_in_if.sink     text_in,
    fsp_out_if.source  parsed_out
);

    fsp_pkg::cmd_t push_cmd;
    fsp_pkg::cmd_t q_head;
    fsp_pkg::wr_t  store_wr;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          run_done;

    fsp_front #(
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .q_full   (q_full),
        .run_done (run_done),
        .push_cmd (push_cmd),
        .push     (push),
        .store_wr (store_wr)
    );

    fsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    fsp_back #(
        .NAME_MAX (NAME_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .parsed_out (parsed_out),
        .store_wr   (store_wr),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop),
        .run_done   (run_done)
    );

endmodule

`default_nettype wire

// ----- bench/fasta_stream_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for fasta_stream_parser: directed rows, then random FASTA files.
// Depends on fsp_pkg, fsp_in_if, fsp_out_if and the parser RTL.

module fasta_stream_parser_tb;

    localparam int NAME_CAP  = 62;
    localparam int ITEMS_MIN = 330;

    typedef enum logic [4:0] {
        LM_START = 5'b00001,
        LM_SEQ   = 5'b00010,
        LM_HLEAD = 5'b00100,
        LM_HNAME = 5'b01000,
        LM_HREST = 5'b10000
    } line_mode_t;

    typedef enum logic [1:0] {PREDICTED, NO_RESULT, ONE_RESULT} row_check_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [11:0] spaces;
        logic        last;
    } parsed_t;

    typedef struct packed {
        logic [7:0]  text;
        logic        fin;
        row_check_t  how;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [11:0] spaces;
    } row_t;

    localparam row_t DIRECTED [28] = '{
        '{8'h41, 1'b0, PREDICTED, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}, // sequence before any header
        '{fsp_pkg::CH_UPPER_Z, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEQ, 8'h7A, 12'd0},
        '{fsp_pkg::CH_SPACE, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{8'hFF, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEQ, 8'hFF, 12'd1},
        '{8'h00, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_CR, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}, // CR before newline
        '{fsp_pkg::CH_LF, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_GT, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEP, 8'h00, 12'd0},
        '{fsp_pkg::CH_SPACE, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{8'h4E, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_CR, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}, // CR inside the name
        '{8'h78, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_SPACE, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{8'h71, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_LF, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_SPACE, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_CR, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{8'h67, 1'b0, PREDICTED, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}, // held CR opens the record
        '{fsp_pkg::CH_LF, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_LF, 1'b0, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{fsp_pkg::CH_GT, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEP, 8'h00, 12'd0},
        '{8'h61, 1'b1, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}, // header only, then EOF
        '{8'h09, 1'b0, PREDICTED, fsp_pkg::KIND_SEQ, 8'h00, 12'd0},
        '{8'h40, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEQ, 8'h40, 12'd0},
        '{8'h5B, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEQ, 8'h5B, 12'd0},
        '{8'h60, 1'b0, ONE_RESULT, fsp_pkg::KIND_SEQ, 8'h60, 12'd0},
        '{fsp_pkg::CH_CR, 1'b1, NO_RESULT, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}, // drop CR at EOF
        '{8'h80, 1'b1, PREDICTED, fsp_pkg::KIND_SEQ, 8'h00, 12'd0}
    };

    logic clk;
    logic rst_n;

    fsp_in_if  text_if ();
    fsp_out_if res_if ();

    fasta_stream_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_if),
        .parsed_out (res_if)
    );

    // parser state mirror
    line_mode_t  line_mode;
    logic        cr_held;
    logic [11:0] held_spaces;
    logic        line_has_text;
    logic        rec_has_seq;
    logic [7:0]  name_bytes [NAME_CAP];
    int          name_len;

    parsed_t step_out [$];
    parsed_t parsed_expect [$];
    int      errors = 0;
    int      items_sent = 0;
    bit      calm_stretch = 1'b0;
    int      ready_hold = 0;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_stretch || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_result(logic [1:0] k, logic [7:0] d, logic [11:0] s);
        parsed_t r;
        r = '{k, d, s, 1'b0};
        if (step_out.size() < fsp_pkg::MAX_RESULTS)
            step_out.insert(step_out.size(), r);
    endfunction

    function automatic void end_line();
        line_mode     = LM_START;
        cr_held       = 1'b0;
        held_spaces   = '0;
        line_has_text = 1'b0;
    endfunction

    function automatic void clear_parser();
        end_line();
        rec_has_seq = 1'b0;
        name_len    = 0;
    endfunction

    function automatic void store_name(logic [7:0] c);
        if (name_len < NAME_CAP)
        begin
            name_bytes[name_len] = c;
            name_len++;
        end
    endfunction

    // reserve: results that may still follow a name run in this transfer
    function automatic void take_text_char(logic [7:0] c, int reserve);
        int run_len;
        logic [7:0] ch;
        ch = c;
        if (line_mode == LM_START)
        begin
            if (ch == fsp_pkg::CH_GT)
            begin
                if (rec_has_seq)
                    add_result(fsp_pkg::KIND_SEP, 8'h00, 12'd0);
                rec_has_seq = 1'b0;
                name_len    = 0;
                line_mode   = LM_HLEAD;
                return;
            end
            line_mode     = LM_SEQ;
            line_has_text = 1'b0;
            held_spaces   = '0;
        end
        unique case (line_mode)
            LM_SEQ:
            begin
                if (ch == fsp_pkg::CH_SPACE)
                begin
                    if (line_has_text && held_spaces != fsp_pkg::SPACE_SAT)
                        held_spaces++;
                    return;
                end
                if (!rec_has_seq)
                begin
                    run_len = fsp_pkg::MAX_RESULTS - 1 - reserve;
                    if (name_len < run_len)
                        run_len = name_len;
                    for (int k = 0; k < run_len; k++)
                        add_result(fsp_pkg::KIND_NAME, name_bytes[k], 12'd0);
                    add_result(fsp_pkg::KIND_NEND, 8'h00, 12'd0);
                    rec_has_seq = 1'b1;
                end
                if (ch >= fsp_pkg::CH_UPPER_A && ch <= fsp_pkg::CH_UPPER_Z)
                    ch = ch + fsp_pkg::CASE_OFFSET;
                add_result(fsp_pkg::KIND_SEQ, ch, held_spaces);
                held_spaces   = '0;
                line_has_text = 1'b1;
            end
            LM_HLEAD:
            begin
                if (ch != fsp_pkg::CH_SPACE)
                begin
                    store_name(ch);
                    line_mode = LM_HNAME;
                end
            end
            LM_HNAME:
            begin
                if (ch == fsp_pkg::CH_SPACE)
                    line_mode = LM_HREST;
                else
                    store_name(ch);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic fin);
        step_out.delete();
        if (b == fsp_pkg::CH_LF)
        begin
            end_line();
        end
        else if (b == fsp_pkg::CH_CR)
        begin
            if (cr_held)
                take_text_char(fsp_pkg::CH_CR, 1);
            cr_held = 1'b1;
        end
        else
        begin
            if (cr_held)
            begin
                cr_held = 1'b0;
                take_text_char(fsp_pkg::CH_CR, (b != fsp_pkg::CH_SPACE) ? 2 : 1);
            end
            take_text_char(b, 1);
        end
        if (fin)
            clear_parser();
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    task automatic send_text(input logic [7:0] b, input logic fin, input row_check_t how,
                             input parsed_t lit);
        int gap;
        @(negedge clk);
        gap = draw_gap();
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_if.valid      <= 1'b1;
        text_if.text_byte  <= b;
        text_if.final_byte <= fin;
        do @(posedge clk); while (!text_if.ready);
        predict_byte(b, fin);
        items_sent++;
        unique case (how)
            PREDICTED:
            begin
                foreach (step_out[k])
                    parsed_expect.insert(parsed_expect.size(), step_out[k]);
            end
            ONE_RESULT:
            begin
                parsed_expect.insert(parsed_expect.size(), lit);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_text(b, 1'b0, PREDICTED, '0);
    endtask

    // hold the sender until every expected result is out
    task automatic drain_results();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (parsed_expect.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] any_but_lf();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == fsp_pkg::CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] name_char();
        string letters;
        logic [7:0] c;
        letters = "abcXYZ019_|.";
        if ($urandom_range(0, 3) != 0)
            return letters[$urandom_range(0, 11)];
        do c = any_but_lf(); while (c == fsp_pkg::CH_SPACE);
        return c;
    endfunction

    function automatic logic [7:0] seq_char();
        string bases;
        logic [7:0] c;
        bases = "ACGTNacgtn-*";
        if ($urandom_range(0, 4) != 0)
            return bases[$urandom_range(0, 11)];
        do c = any_but_lf(); while (c == fsp_pkg::CH_SPACE);
        return c;
    endfunction

    task automatic line_break();
        if ($urandom_range(0, 4) == 0)
            put_byte(fsp_pkg::CH_CR);
        put_byte(fsp_pkg::CH_LF);
    endtask

    task automatic header_line(input int nlen);
        put_byte(fsp_pkg::CH_GT);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put_byte(fsp_pkg::CH_SPACE);
        repeat (nlen) put_byte(name_char());
        if ($urandom_range(0, 1) == 0)
        begin
            put_byte(fsp_pkg::CH_SPACE);
            repeat ($urandom_range(0, 4)) put_byte(any_but_lf());
        end
        line_break();
    endtask

    task automatic sequence_line(input int len);
        repeat ($urandom_range(0, 2)) put_byte(fsp_pkg::CH_SPACE);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) put_byte(fsp_pkg::CH_SPACE);
            put_byte(seq_char());
        end
        repeat ($urandom_range(0, 2)) put_byte(fsp_pkg::CH_SPACE);
        line_break();
    endtask

    function automatic int pick_name_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 10)
            return $urandom_range(55, 70);
        return $urandom_range(1, 8);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm_stretch = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold == 0)
                ready_hold = draw_gap();
            if (ready_hold > 0)
            begin
                res_if.ready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        parsed_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (parsed_expect.size() == 0)
            begin
                $error("unexpected result: kind %0d out_byte %02h", res_if.kind, res_if.out_byte);
                errors++;
            end
            else
            begin
                want = parsed_expect.pop_front();
                if (res_if.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, res_if.kind);
                    errors++;
                end
                if (res_if.out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, actual %02h", want.data, res_if.out_byte);
                    errors++;
                end
                if (res_if.spaces_before !== want.spaces)
                begin
                    $error("spaces_before: expected %0d, actual %0d",
                           want.spaces, res_if.spaces_before);
                    errors++;
                end
                if (res_if.run_last !== want.last)
                begin
                    $error("run_last: expected %0d, actual %0d", want.last, res_if.run_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("fasta_stream_parser regression: fail");
        $finish;
    end

    initial
    begin
        parsed_t lit;
        int r;
        rst_n              = 1'b0;
        text_if.valid      = 1'b0;
        text_if.text_byte  = 8'h00;
        text_if.final_byte = 1'b0;
        clear_parser();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            lit = '{DIRECTED[i].kind, DIRECTED[i].data, DIRECTED[i].spaces, 1'b1};
            send_text(DIRECTED[i].text, DIRECTED[i].fin, DIRECTED[i].how, lit);
        end
        drain_results();

        // longest name, then a held CR opening the record: run is cut short
        header_line(66);
        put_byte(fsp_pkg::CH_CR);
        put_byte(8'h41);
        line_break();
        drain_results();

        while (items_sent < ITEMS_MIN)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 8))
                    send_text(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0,
                              PREDICTED, '0);
            end
            else if (r < 14)
            begin
                repeat ($urandom_range(0, 3)) put_byte(fsp_pkg::CH_SPACE);
                line_break();
            end
            else if (r < 17)
            begin
                send_text(any_but_lf(), 1'b1, PREDICTED, '0);
                if ($urandom_range(0, 1) == 0)
                    drain_results();
            end
            else if (r < 21)
            begin
                put_byte(fsp_pkg::CH_CR);
                put_byte(seq_char());
                sequence_line($urandom_range(0, 6));
            end
            else if (r < 45)
            begin
                header_line(pick_name_len());
            end
            else
            begin
                sequence_line($urandom_range(1, 20));
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("fasta_stream_parser regression: pass");
        else
            $display("fasta_stream_parser regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_if.sv
hw/rtl/fsp_front.sv
hw/rtl/fsp_queue.sv
hw/rtl/fsp_back.sv
hw/rtl/fasta_stream_parser.sv
bench/fasta_stream_parser_tb.sv
